/* rtl/nafmt_pkg.sv */
// ----------------------------------------------------------------------------
// nafmt_pkg: shared types and constants for the number formatter
// Format codes, ASCII constants, the state type and the nibble-to-ASCII map.
// ----------------------------------------------------------------------------
package nafmt_pkg;

   localparam int unsigned VALUE_W   = 32;
   localparam int unsigned ACTION_W  = 3;
   localparam int unsigned CHAR_W    = 8;
   localparam int unsigned DEC_DIGITS = 10;
   localparam int unsigned DIG_W     = 4 * DEC_DIGITS;   // 40-bit digit register
   localparam int unsigned CNT_W     = 4;                // holds up to ten digits
   localparam int unsigned BIT_CNT_W = 5;                // counts 32 input bits

   // format selector codes; anything above MODE_DEC also formats as decimal
   localparam logic [ACTION_W-1:0] MODE_HEX16_AUTO = 3'd0;
   localparam logic [ACTION_W-1:0] MODE_HEX32      = 3'd1;
   localparam logic [ACTION_W-1:0] MODE_HEX16      = 3'd2;
   localparam logic [ACTION_W-1:0] MODE_HEX8       = 3'd3;
   localparam logic [ACTION_W-1:0] MODE_DEC        = 3'd4;

   localparam logic [CHAR_W-1:0] CHAR_ZERO          = 8'h30;  // '0'
   localparam logic [CHAR_W-1:0] CHAR_X             = 8'h78;  // 'x'
   localparam logic [CHAR_W-1:0] HEX_LETTER_OFFSET  = 8'd55;  // 10 -> 'A'

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
      logic [CHAR_W-1:0] wide;
      wide = {4'd0, nib};
      if (nib > 4'd9) begin
         return wide + HEX_LETTER_OFFSET;
      end
      return wide + CHAR_ZERO;
   endfunction

endpackage

/* rtl/number_to_ascii_formatter_core.sv */
// ----------------------------------------------------------------------------
// number_to_ascii_formatter_core: number to ASCII character stream
// Formats a 32-bit number as hex or decimal text, one character per strobe.
// ----------------------------------------------------------------------------
// Usage
//   Request channel: drive req_action and req_value and raise start while
//   busy is low; the request is taken at that clock edge. busy stays high
//   until the final character has gone out.
//   Response channel: each character appears on rsp_character for exactly
//   one cycle with rsp_valid high; rsp_last marks the final character of the
//   number. The receiver cannot stall: every strobed character is taken.
//   Timing: hex formats emit one character per cycle starting the cycle
//   after the request. Decimal runs a bit-serial shift-and-add-3 conversion
//   on the 40-bit BCD register, one input bit per cycle, then drops
//   leading zeros one at a time while keeping at least one digit, then
//   emits one digit per cycle.
//   One number at a time: the next request is taken once busy falls.
//   Reset returns the controller to idle; data registers are not cleared.
// ----------------------------------------------------------------------------
module number_to_ascii_formatter_core
   import nafmt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [VALUE_W-1:0]  req_value,
   output logic                rsp_valid,
   output logic [CHAR_W-1:0]   rsp_character,
   output logic                rsp_last
);

   state_type state_ff, state_in;

   // digit shift register: hex nibbles or BCD digits, most significant on top
   logic [DIG_W-1:0]     dig_ff, dig_in;
   // binary shift register feeding the decimal conversion one bit a cycle
   logic [VALUE_W-1:0]   bin_ff, bin_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;       // digits left to emit
   logic [1:0]           pre_ff, pre_in;       // "0x" prefix characters left
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;

   logic                 accept;
   logic                 top_zero;
   logic [DIG_W-1:0]     dig_adj;

   assign accept   = start && (state_ff == ST_IDLE);
   assign top_zero = (dig_ff[DIG_W-1 -: 4] == 4'd0);

   // add 3 to every BCD digit of 5 or more before the next shift
   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         if (dig_ff[4*i +: 4] >= 4'd5) begin
            dig_adj[4*i +: 4] = dig_ff[4*i +: 4] + 4'd3;
         end else begin
            dig_adj[4*i +: 4] = dig_ff[4*i +: 4];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_action >= MODE_DEC) begin
                  state_in = ST_CONVERT;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_CONVERT: begin
            if (bit_cnt_ff == BIT_CNT_W'(VALUE_W - 1)) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (!(top_zero && cnt_ff > CNT_W'(1))) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (pre_ff == 2'd0 && cnt_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy          = (state_ff != ST_IDLE);
      rsp_valid     = 1'b0;
      rsp_character = hex_char(dig_ff[DIG_W-1 -: 4]);
      rsp_last      = 1'b0;
      case (state_ff)
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (pre_ff == 2'd2) begin
               rsp_character = CHAR_ZERO;
            end else if (pre_ff == 2'd1) begin
               rsp_character = CHAR_X;
            end else begin
               rsp_last = (cnt_ff == CNT_W'(1));
            end
         end
         default: begin
            rsp_valid = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      dig_in     = dig_ff;
      bin_in     = bin_ff;
      cnt_in     = cnt_ff;
      pre_in     = pre_ff;
      bit_cnt_in = bit_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            // load the digit register left-aligned for the chosen format
            bin_in     = req_value;
            bit_cnt_in = '0;
            pre_in     = 2'd0;
            case (req_action)
               MODE_HEX16_AUTO: begin
                  pre_in = 2'd2;
                  if (req_value[15:8] == 8'd0) begin
                     dig_in = {req_value[7:0], 32'd0};
                     cnt_in = CNT_W'(2);
                  end else begin
                     dig_in = {req_value[15:0], 24'd0};
                     cnt_in = CNT_W'(4);
                  end
               end
               MODE_HEX32: begin
                  pre_in = 2'd2;
                  dig_in = {req_value, 8'd0};
                  cnt_in = CNT_W'(8);
               end
               MODE_HEX16: begin
                  dig_in = {req_value[15:0], 24'd0};
                  cnt_in = CNT_W'(4);
               end
               MODE_HEX8: begin
                  dig_in = {req_value[7:0], 32'd0};
                  cnt_in = CNT_W'(2);
               end
               default: begin
                  // decimal: clear BCD, then convert all 32 input bits
                  dig_in = '0;
                  cnt_in = CNT_W'(DEC_DIGITS);
               end
            endcase
         end
         ST_CONVERT: begin
            // shift one binary bit into the adjusted BCD register
            dig_in     = {dig_adj[DIG_W-2:0], bin_ff[VALUE_W-1]};
            bin_in     = {bin_ff[VALUE_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
         end
         ST_SKIP: begin
            // drop leading zeros, keep at least one digit
            if (top_zero && cnt_ff > CNT_W'(1)) begin
               dig_in = {dig_ff[DIG_W-5:0], 4'd0};
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_EMIT: begin
            if (pre_ff != 2'd0) begin
               pre_in = pre_ff - 2'd1;
            end else begin
               dig_in = {dig_ff[DIG_W-5:0], 4'd0};
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         default: begin
            dig_in = dig_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept || state_ff != ST_IDLE) begin
         dig_ff     <= dig_in;
         bin_ff     <= bin_in;
         cnt_ff     <= cnt_in;
         pre_ff     <= pre_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

endmodule
